FILE: hdl/htw_pkg.sv
// ----------------------------------------------------------------------------
// htw_pkg
// Shared types and codes of the hierarchical timer wheel: result status
// codes, bucket entry layout and the controller to datapath command bundle.
// ----------------------------------------------------------------------------
package htw_pkg;

	// fixed field widths of the item payloads
	localparam int SLOT_W  = 6;
	localparam int TIME_W  = 32;
	localparam int CODE_W  = 4;
	localparam int PARAM_W = 32;
	localparam int STAT_W  = 3;

	// result status codes
	localparam logic [STAT_W-1:0] ST_ARMED      = 3'd0;
	localparam logic [STAT_W-1:0] ST_NOT_FUTURE = 3'd1;
	localparam logic [STAT_W-1:0] ST_PENDING    = 3'd2;
	localparam logic [STAT_W-1:0] ST_FIRED      = 3'd3;
	localparam logic [STAT_W-1:0] ST_TICK_IDLE  = 3'd4;

	// func codes of an input item
	localparam logic FN_SET  = 1'b0;
	localparam logic FN_TICK = 1'b1;

	// bucket list descriptor: valid, first and last slot
	typedef struct packed {
		logic              vld;
		logic [SLOT_W-1:0] head;
		logic [SLOT_W-1:0] tail;
	} bkt_t;

	// source of the bucket read address
	typedef enum logic [1:0] {
		RS_SET = 2'd0,
		RS_NOW = 2'd1,
		RS_DUE = 2'd2
	} rsel_t;

	// commands from the controller
	typedef struct packed {
		logic       ld_in;
		logic       inc;
		logic       rd;
		rsel_t      rsel;
		logic [1:0] wheel;
		logic       take;
		logic       append;
		logic       adv;
		logic       emit_set;
		logic       emit_fire;
		logic       emit_idle;
		logic       clr_step;
	} cmd_t;

	// status back to the controller
	typedef struct packed {
		logic bk_valid;
		logic at_tail;
		logic out_free;
		logic dz0;
		logic dz1;
		logic dz2;
		logic clr_last;
		logic cfg_wr;
	} stat_t;

endpackage

FILE: hdl/htw_if.sv
// ----------------------------------------------------------------------------
// htw_in_if / htw_out_if
// Valid/ready channels carrying the input items and the result items.
// ----------------------------------------------------------------------------
interface htw_in_if;
	logic                         valid;
	logic                         ready;
	logic                         func;
	logic [htw_pkg::SLOT_W-1:0]   timer_slot;
	logic [htw_pkg::TIME_W-1:0]   expiry_time;
	logic [htw_pkg::CODE_W-1:0]   callback_code;
	logic [htw_pkg::PARAM_W-1:0]  callback_param;

	modport source (output valid, func, timer_slot, expiry_time, callback_code,
		callback_param, input ready);
	modport sink (input valid, func, timer_slot, expiry_time, callback_code,
		callback_param, output ready);
endinterface

interface htw_out_if;
	logic                         valid;
	logic                         ready;
	logic [htw_pkg::STAT_W-1:0]   status;
	logic [htw_pkg::SLOT_W-1:0]   fired_slot;
	logic [htw_pkg::CODE_W-1:0]   fired_code;
	logic [htw_pkg::PARAM_W-1:0]  fired_param;
	logic [htw_pkg::TIME_W-1:0]   now_time;
	logic                         last;

	modport source (output valid, status, fired_slot, fired_code, fired_param,
		now_time, last, input ready);
	modport sink (input valid, status, fired_slot, fired_code, fired_param,
		now_time, last, output ready);
endinterface

FILE: hdl/htw_dp.sv
// ----------------------------------------------------------------------------
// htw_dp
// Datapath of the timer wheel: current time, bucket descriptor memory,
// slot memories, pending bits, list cursor and the result register.
// ----------------------------------------------------------------------------
module htw_dp #(
	parameter int BUCKET_BITS = 8,
	parameter int NUM_SLOTS   = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  htw_pkg::cmd_t                 cmd,
	output htw_pkg::stat_t                st,
	input  logic                          cfg_wr,
	input  logic [31:0]                   cfg_data,
	output logic [31:0]                   start_time,
	input  logic [htw_pkg::SLOT_W-1:0]    in_slot,
	input  logic [htw_pkg::TIME_W-1:0]    in_time,
	input  logic [htw_pkg::CODE_W-1:0]    in_code,
	input  logic [htw_pkg::PARAM_W-1:0]   in_param,
	htw_out_if.source                     out_ch
);

	localparam int BKW = 2 + BUCKET_BITS;
	localparam int NB4 = 4 << BUCKET_BITS;
	localparam int SAW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

	// memories
	htw_pkg::bkt_t                bk_mem    [NB4];
	logic [htw_pkg::TIME_W-1:0]   due_mem   [NUM_SLOTS];
	logic [htw_pkg::CODE_W-1:0]   code_mem  [NUM_SLOTS];
	logic [htw_pkg::PARAM_W-1:0]  param_mem [NUM_SLOTS];
	logic [htw_pkg::SLOT_W-1:0]   next_mem  [NUM_SLOTS];

	logic [31:0]                  start_q;
	logic [htw_pkg::TIME_W-1:0]   now_q;
	logic [NUM_SLOTS-1:0]         pend_q;
	logic [BKW-1:0]               clr_q;
	logic [BKW-1:0]               bk_addr_q;
	htw_pkg::bkt_t                bk_rd_q;
	logic [htw_pkg::SLOT_W-1:0]   cur_q;
	logic [htw_pkg::SLOT_W-1:0]   tail_q;
	logic [htw_pkg::TIME_W-1:0]   due_rd_q;
	logic [htw_pkg::CODE_W-1:0]   code_rd_q;
	logic [htw_pkg::PARAM_W-1:0]  param_rd_q;
	logic [htw_pkg::SLOT_W-1:0]   next_rd_q;

	logic [htw_pkg::SLOT_W-1:0]   in_slot_q;
	logic [htw_pkg::TIME_W-1:0]   in_time_q;
	logic [htw_pkg::CODE_W-1:0]   in_code_q;
	logic [htw_pkg::PARAM_W-1:0]  in_param_q;

	logic                         out_valid_q;
	logic [htw_pkg::STAT_W-1:0]   out_status_q;
	logic [htw_pkg::SLOT_W-1:0]   out_slot_q;
	logic [htw_pkg::CODE_W-1:0]   out_code_q;
	logic [htw_pkg::PARAM_W-1:0]  out_param_q;
	logic [htw_pkg::TIME_W-1:0]   out_now_q;
	logic                         out_last_q;

	logic [1:0]                   set_wheel;
	logic [htw_pkg::TIME_W-1:0]   set_diff;
	logic                         slot_bad;
	logic                         slot_busy;
	logic [htw_pkg::STAT_W-1:0]   set_st;
	logic                         commit;
	logic [BKW-1:0]               rd_addr;
	logic [htw_pkg::SLOT_W-1:0]   app_slot;
	logic                         out_free;
	logic [SAW-1:0]               cur_idx;
	logic [SAW-1:0]               in_idx;

	function automatic logic [BKW-1:0] bkt_addr(input logic [1:0] w,
			input logic [htw_pkg::TIME_W-1:0] t);
		logic [BUCKET_BITS-1:0] dg;
		dg = t[int'(w) * BUCKET_BITS +: BUCKET_BITS];
		return {w, dg};
	endfunction

	assign cur_idx = cur_q[SAW-1:0];
	assign in_idx  = in_slot_q[SAW-1:0];

	// wheel choice: lowest wheel whose upper bits agree with now
	always_comb begin
		set_wheel = 2'd3;
		for (int w = 2; w >= 0; w--) begin
			if (((now_q ^ in_time_q) >> (BUCKET_BITS * (w + 1))) == '0)
				set_wheel = 2'(w);
		end
	end

	// set item checks
	assign set_diff  = in_time_q - now_q;
	assign slot_bad  = {1'b0, in_slot_q} >= 7'(NUM_SLOTS);
	assign slot_busy = slot_bad || pend_q[in_idx];
	always_comb begin
		if (slot_busy)
			set_st = htw_pkg::ST_PENDING;
		else if (set_diff == '0 || set_diff[htw_pkg::TIME_W-1])
			set_st = htw_pkg::ST_NOT_FUTURE;
		else
			set_st = htw_pkg::ST_ARMED;
	end
	assign commit = cmd.emit_set && (set_st == htw_pkg::ST_ARMED);

	// bucket read address
	always_comb begin
		unique case (cmd.rsel)
			htw_pkg::RS_SET: rd_addr = bkt_addr(set_wheel, in_time_q);
			htw_pkg::RS_NOW: rd_addr = bkt_addr(cmd.wheel, now_q);
			htw_pkg::RS_DUE: rd_addr = bkt_addr(cmd.wheel, due_rd_q);
			default:         rd_addr = bk_addr_q;
		endcase
	end

	assign app_slot = commit ? in_slot_q : cur_q;

	// bucket descriptor memory
	always_ff @(posedge clk) begin
		if (cmd.clr_step) begin
			bk_mem[clr_q] <= '0;
		end else if (cmd.take) begin
			bk_mem[bk_addr_q] <= '0;
		end else if (cmd.append || commit) begin
			if (bk_rd_q.vld)
				bk_mem[bk_addr_q] <= '{vld: 1'b1, head: bk_rd_q.head, tail: app_slot};
			else
				bk_mem[bk_addr_q] <= '{vld: 1'b1, head: app_slot, tail: app_slot};
		end
		if (cmd.rd)
			bk_rd_q <= bk_mem[rd_addr];
	end

	// slot memories, read every cycle at the cursor
	always_ff @(posedge clk) begin
		if (commit) begin
			due_mem[in_idx]   <= in_time_q;
			code_mem[in_idx]  <= in_code_q;
			param_mem[in_idx] <= in_param_q;
		end
		if ((cmd.append || commit) && bk_rd_q.vld)
			next_mem[bk_rd_q.tail[SAW-1:0]] <= app_slot;
		due_rd_q   <= due_mem[cur_idx];
		code_rd_q  <= code_mem[cur_idx];
		param_rd_q <= param_mem[cur_idx];
		next_rd_q  <= next_mem[cur_idx];
	end

	// bucket address, cursor and captured input
	always_ff @(posedge clk) begin
		if (cmd.rd)
			bk_addr_q <= rd_addr;
		if (cmd.take) begin
			cur_q  <= bk_rd_q.head;
			tail_q <= bk_rd_q.tail;
		end else if (cmd.adv) begin
			cur_q <= next_rd_q;
		end
		if (cmd.ld_in) begin
			in_slot_q  <= in_slot;
			in_time_q  <= in_time;
			in_code_q  <= in_code;
			in_param_q <= in_param;
		end
	end

	// time, start register, pending bits and clearing counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			now_q   <= '0;
			pend_q  <= '0;
			clr_q   <= '0;
		end else begin
			if (cfg_wr) begin
				start_q <= cfg_data;
				now_q   <= cfg_data;
				pend_q  <= '0;
				clr_q   <= '0;
			end else begin
				if (cmd.inc)
					now_q <= now_q + 1'b1;
				if (cmd.clr_step)
					clr_q <= clr_q + 1'b1;
				if (commit)
					pend_q[in_idx] <= 1'b1;
				if (cmd.emit_fire)
					pend_q[cur_idx] <= 1'b0;
			end
		end
	end

	// result register
	assign out_free = !out_valid_q || out_ch.ready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_set || cmd.emit_fire || cmd.emit_idle) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_set) begin
			out_status_q <= set_st;
			out_slot_q   <= in_slot_q;
			out_code_q   <= '0;
			out_param_q  <= '0;
			out_last_q   <= 1'b1;
		end else if (cmd.emit_fire) begin
			out_status_q <= htw_pkg::ST_FIRED;
			out_slot_q   <= cur_q;
			out_code_q   <= code_rd_q;
			out_param_q  <= param_rd_q;
			out_last_q   <= cur_q == tail_q;
		end else if (cmd.emit_idle) begin
			out_status_q <= htw_pkg::ST_TICK_IDLE;
			out_slot_q   <= '0;
			out_code_q   <= '0;
			out_param_q  <= '0;
			out_last_q   <= 1'b1;
		end
		if (cmd.emit_set || cmd.emit_fire || cmd.emit_idle)
			out_now_q <= now_q;
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.status      = out_status_q;
	assign out_ch.fired_slot  = out_slot_q;
	assign out_ch.fired_code  = out_code_q;
	assign out_ch.fired_param = out_param_q;
	assign out_ch.now_time    = out_now_q;
	assign out_ch.last        = out_last_q;

	assign start_time = start_q;

	// status to the controller
	assign st.bk_valid = bk_rd_q.vld;
	assign st.at_tail  = cur_q == tail_q;
	assign st.out_free = out_free;
	assign st.dz0      = now_q[BUCKET_BITS-1:0] == '0;
	assign st.dz1      = now_q[2*BUCKET_BITS-1:BUCKET_BITS] == '0;
	assign st.dz2      = now_q[3*BUCKET_BITS-1:2*BUCKET_BITS] == '0;
	assign st.clr_last = &clr_q;
	assign st.cfg_wr   = cfg_wr;

	// checks
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_set || cmd.emit_fire || cmd.emit_idle) |-> out_free)
		else $error("result written while result register is held");
	a_fire_pending: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_fire |-> pend_q[cur_idx])
		else $error("fired slot was not pending");
	a_take_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |-> bk_rd_q.vld)
		else $error("empty bucket taken");

endmodule

FILE: hdl/htw_ctrl.sv
// ----------------------------------------------------------------------------
// htw_ctrl
// Sequencer of the timer wheel: set item, tick with cascades from the upper
// wheels, firing walk of the wheel-0 bucket and the bucket clearing pass.
// ----------------------------------------------------------------------------
module htw_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_func,
	output logic            in_ready,
	input  htw_pkg::stat_t  st,
	output htw_pkg::cmd_t   cmd
);

	typedef enum logic [3:0] {
		S_CLR,
		S_IDLE,
		S_SET_RD,
		S_SET_WR,
		S_TICK_INC,
		S_TICK_CHK,
		S_CASC_RD,
		S_CASC_HEAD,
		S_CASC_WAIT,
		S_CASC_TGT,
		S_CASC_APP,
		S_FIRE_RD,
		S_FIRE_HEAD,
		S_FIRE_WAIT,
		S_FIRE_EMIT,
		S_IDLE_OUT
	} state_t;

	state_t     state_q;
	logic [1:0] w_q;

	assign in_ready = state_q == S_IDLE;

	// state and current cascade wheel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			w_q     <= 2'd0;
		end else if (st.cfg_wr) begin
			state_q <= S_CLR;
		end else begin
			unique case (state_q)
				S_CLR: begin
					if (st.clr_last)
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid)
						state_q <= (in_func == htw_pkg::FN_TICK) ? S_TICK_INC : S_SET_RD;
				end
				S_SET_RD:   state_q <= S_SET_WR;
				S_SET_WR: begin
					if (st.out_free)
						state_q <= S_IDLE;
				end
				S_TICK_INC: state_q <= S_TICK_CHK;
				S_TICK_CHK: begin
					if (!st.dz0) begin
						state_q <= S_FIRE_RD;
					end else begin
						state_q <= S_CASC_RD;
						if (!st.dz1)
							w_q <= 2'd1;
						else if (!st.dz2)
							w_q <= 2'd2;
						else
							w_q <= 2'd3;
					end
				end
				S_CASC_RD:  state_q <= S_CASC_HEAD;
				S_CASC_HEAD: begin
					if (st.bk_valid)
						state_q <= S_CASC_WAIT;
					else if (w_q == 2'd1)
						state_q <= S_FIRE_RD;
					else begin
						w_q     <= w_q - 2'd1;
						state_q <= S_CASC_RD;
					end
				end
				S_CASC_WAIT: state_q <= S_CASC_TGT;
				S_CASC_TGT:  state_q <= S_CASC_APP;
				S_CASC_APP: begin
					if (!st.at_tail)
						state_q <= S_CASC_WAIT;
					else if (w_q == 2'd1)
						state_q <= S_FIRE_RD;
					else begin
						w_q     <= w_q - 2'd1;
						state_q <= S_CASC_RD;
					end
				end
				S_FIRE_RD:  state_q <= S_FIRE_HEAD;
				S_FIRE_HEAD: begin
					state_q <= st.bk_valid ? S_FIRE_WAIT : S_IDLE_OUT;
				end
				S_FIRE_WAIT: state_q <= S_FIRE_EMIT;
				S_FIRE_EMIT: begin
					if (st.out_free)
						state_q <= st.at_tail ? S_IDLE : S_FIRE_WAIT;
				end
				S_IDLE_OUT: begin
					if (st.out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_CLR;
			endcase
		end
	end

	// command decode
	always_comb begin
		cmd       = '0;
		cmd.rsel  = htw_pkg::RS_NOW;
		cmd.wheel = w_q;
		unique case (state_q)
			S_CLR:       cmd.clr_step = 1'b1;
			S_IDLE:      cmd.ld_in = in_valid;
			S_SET_RD: begin
				cmd.rd   = 1'b1;
				cmd.rsel = htw_pkg::RS_SET;
			end
			S_SET_WR:    cmd.emit_set = st.out_free;
			S_TICK_INC:  cmd.inc = 1'b1;
			S_CASC_RD:   cmd.rd = 1'b1;
			S_CASC_HEAD: cmd.take = st.bk_valid;
			S_CASC_TGT: begin
				cmd.rd    = 1'b1;
				cmd.rsel  = htw_pkg::RS_DUE;
				cmd.wheel = w_q - 2'd1;
			end
			S_CASC_APP: begin
				cmd.append = 1'b1;
				cmd.adv    = !st.at_tail;
			end
			S_FIRE_RD: begin
				cmd.rd    = 1'b1;
				cmd.wheel = 2'd0;
			end
			S_FIRE_HEAD: cmd.take = st.bk_valid;
			S_FIRE_EMIT: begin
				cmd.emit_fire = st.out_free;
				cmd.adv       = st.out_free && !st.at_tail;
			end
			S_IDLE_OUT:  cmd.emit_idle = st.out_free;
			default: ;
		endcase
	end

	// checks
	a_cfg_clear: assert property (@(posedge clk) disable iff (!arst_n)
		st.cfg_wr |=> state_q == S_CLR)
		else $error("start time write did not start the clearing pass");

endmodule

FILE: hdl/hierarchical_timer_wheel_unit.sv
// ----------------------------------------------------------------------------
// hierarchical_timer_wheel_unit
// Four-level hierarchical timer wheel over a pool of timer slots.
// ----------------------------------------------------------------------------
// One item at a time. A set item is captured, its bucket descriptor read,
// then its result written. A tick advances the time and checks the digits,
// cascades each upper wheel at a digit rollover by taking its bucket and
// moving each timer to its target bucket, then takes the wheel-0 bucket and
// fires each timer in it, or gives the idle result for an empty bucket. The
// steps follow from the single read and write port of the bucket descriptor
// memory and the registered reads of the slot memories, walked one list
// element at a time. After reset and after every write of start_time a
// clearing pass empties all 4*2^BUCKET_BITS buckets; no item is taken
// during it. A result waiting in the output register stalls the walk.
module hierarchical_timer_wheel_unit #(
	parameter int BUCKET_BITS = 8,
	parameter int NUM_SLOTS   = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	htw_in_if.sink       in_ch,
	htw_out_if.source    out_ch
);

	htw_pkg::cmd_t  cmd;
	htw_pkg::stat_t st;
	logic           cfg_wr;
	logic [31:0]    start_time;

	// register write decode, start_time at byte address zero
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];
	assign prdata = paddr[2] ? 32'd0 : start_time;

	htw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_func  (in_ch.func),
		.in_ready (in_ch.ready),
		.st       (st),
		.cmd      (cmd)
	);

	htw_dp #(
		.BUCKET_BITS (BUCKET_BITS),
		.NUM_SLOTS   (NUM_SLOTS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.st         (st),
		.cfg_wr     (cfg_wr),
		.cfg_data   (pwdata),
		.start_time (start_time),
		.in_slot    (in_ch.timer_slot),
		.in_time    (in_ch.expiry_time),
		.in_code    (in_ch.callback_code),
		.in_param   (in_ch.callback_param),
		.out_ch     (out_ch)
	);

endmodule
